FILE: hdl/modular_exponentiation_macros.svh
// ----------------------------------------------------------------------------
// modular exponentiation assertion macros
// shared clocked assertion forms used by the rtl files
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// checked at every edge outside reset
`define MEXP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define MEXP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// widths, control word layout and the microprogram of the exponentiator
// ----------------------------------------------------------------------------
package mexp_pkg;

   localparam int MOD_WIDTH      = 32;
   localparam int EXP_WIDTH      = 63;
   // exponent register also holds modulus minus two in inverse mode
   localparam int EREG_WIDTH     = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;
   localparam int ECNT_WIDTH     = $clog2(EREG_WIDTH);
   localparam int MCNT_WIDTH     = $clog2(MOD_WIDTH);
   localparam int REQ_DATA_WIDTH = ((2 * MOD_WIDTH + EXP_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = ((MOD_WIDTH + 7) / 8) * 8;
   localparam int PC_WIDTH       = 4;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_LOAD_EXP,
      OP_SETUP_RBASE,
      OP_MUL_STEP,
      OP_SAVE_BASE,
      OP_SETUP_SQ,
      OP_SAVE_ACC,
      OP_SETUP_MB,
      OP_NEXT_BIT,
      OP_OUT_ACC,
      OP_OUT_BAD,
      OP_OUT_ONE
   } op_type;

   typedef enum logic [2:0] {
      C_NEXT,
      C_ALWAYS,
      C_NO_REQ,
      C_BAD,
      C_EXP_ZERO,
      C_MUL_MORE,
      C_EBIT_ZERO,
      C_ECNT_MORE
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [PC_WIDTH-1:0] target;
      logic                wait_out;
   } ucode_type;

   typedef struct packed {
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic bad;
      logic exp_zero;
      logic mul_more;
      logic ebit;
      logic ecnt_more;
   } status_type;

   // step addresses
   localparam logic [PC_WIDTH-1:0] STEP_IDLE     = 4'd0;
   localparam logic [PC_WIDTH-1:0] STEP_CHECK    = 4'd1;
   localparam logic [PC_WIDTH-1:0] STEP_RBASE    = 4'd2;
   localparam logic [PC_WIDTH-1:0] STEP_RBASE_MUL = 4'd3;
   localparam logic [PC_WIDTH-1:0] STEP_SAVE_BASE = 4'd4;
   localparam logic [PC_WIDTH-1:0] STEP_SQ       = 4'd5;
   localparam logic [PC_WIDTH-1:0] STEP_SQ_MUL   = 4'd6;
   localparam logic [PC_WIDTH-1:0] STEP_SQ_SAVE  = 4'd7;
   localparam logic [PC_WIDTH-1:0] STEP_MB       = 4'd8;
   localparam logic [PC_WIDTH-1:0] STEP_MB_MUL   = 4'd9;
   localparam logic [PC_WIDTH-1:0] STEP_MB_SAVE  = 4'd10;
   localparam logic [PC_WIDTH-1:0] STEP_NEXT_BIT = 4'd11;
   localparam logic [PC_WIDTH-1:0] STEP_OUT_ACC  = 4'd12;
   localparam logic [PC_WIDTH-1:0] STEP_OUT_BAD  = 4'd13;
   localparam logic [PC_WIDTH-1:0] STEP_OUT_ONE  = 4'd14;

   function automatic ucode_type uword(input op_type op, input cond_type cond,
                                       input logic [PC_WIDTH-1:0] target,
                                       input logic wait_out);
      ucode_type w;
      w.op       = op;
      w.cond     = cond;
      w.target   = target;
      w.wait_out = wait_out;
      return w;
   endfunction

   // the microprogram: jump to target when cond holds, else fall through
   function automatic ucode_type ucode_rom(input logic [PC_WIDTH-1:0] pc);
      ucode_type w;
      w = uword(OP_NOP, C_ALWAYS, STEP_IDLE, 1'b0);
      unique case (pc)
         STEP_IDLE:      w = uword(OP_ACCEPT, C_NO_REQ, STEP_IDLE, 1'b0);
         STEP_CHECK:     w = uword(OP_LOAD_EXP, C_BAD, STEP_OUT_BAD, 1'b0);
         STEP_RBASE:     w = uword(OP_SETUP_RBASE, C_EXP_ZERO, STEP_OUT_ONE, 1'b0);
         STEP_RBASE_MUL: w = uword(OP_MUL_STEP, C_MUL_MORE, STEP_RBASE_MUL, 1'b0);
         STEP_SAVE_BASE: w = uword(OP_SAVE_BASE, C_NEXT, STEP_IDLE, 1'b0);
         STEP_SQ:        w = uword(OP_SETUP_SQ, C_NEXT, STEP_IDLE, 1'b0);
         STEP_SQ_MUL:    w = uword(OP_MUL_STEP, C_MUL_MORE, STEP_SQ_MUL, 1'b0);
         STEP_SQ_SAVE:   w = uword(OP_SAVE_ACC, C_EBIT_ZERO, STEP_NEXT_BIT, 1'b0);
         STEP_MB:        w = uword(OP_SETUP_MB, C_NEXT, STEP_IDLE, 1'b0);
         STEP_MB_MUL:    w = uword(OP_MUL_STEP, C_MUL_MORE, STEP_MB_MUL, 1'b0);
         STEP_MB_SAVE:   w = uword(OP_SAVE_ACC, C_NEXT, STEP_IDLE, 1'b0);
         STEP_NEXT_BIT:  w = uword(OP_NEXT_BIT, C_ECNT_MORE, STEP_SQ, 1'b0);
         STEP_OUT_ACC:   w = uword(OP_OUT_ACC, C_ALWAYS, STEP_IDLE, 1'b1);
         STEP_OUT_BAD:   w = uword(OP_OUT_BAD, C_ALWAYS, STEP_IDLE, 1'b1);
         STEP_OUT_ONE:   w = uword(OP_OUT_ONE, C_ALWAYS, STEP_IDLE, 1'b1);
         default:        w = uword(OP_NOP, C_ALWAYS, STEP_IDLE, 1'b0);
      endcase
      return w;
   endfunction

endpackage

FILE: hdl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// base to the power exponent modulo a modulus, square-and-multiply
// ----------------------------------------------------------------------------
// One transaction in, one out. The run time of a request grows with E, the
// exponent register width (63 here, every bit is scanned), and with P, the
// number of ones in the exponent used (modulus minus two in inverse mode).
// It is set by the bit-serial modular multiplier, which retires one
// multiplier bit per cycle and runs once for the base reduction, once per
// exponent bit for the square and once more per set bit. A rejected modulus
// returns from the check step and a zero exponent from the base setup step,
// before any multiply. A finished result sits in the output register while
// the next request is taken in.
`include "modular_exponentiation_macros.svh"

module modular_exponentiation (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // base_value, exponent_value, modulus_value, zero fill
   input  logic [mexp_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // req_type
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // power_result
   output logic [mexp_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   // bad_modulus
   output logic                                  rsp_tuser
);
   import mexp_pkg::*;

   ctrl_type             ctrl;
   status_type           status;
   logic [MOD_WIDTH-1:0] acc_value;
   logic                 out_load;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MOD_WIDTH-1:0] rsp_result_ff, rsp_result_in;
   logic                 rsp_bad_ff, rsp_bad_in;

   mexp_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .out_full   (rsp_valid_ff),
      .status     (status),
      .ctrl       (ctrl),
      .req_tready (req_tready)
   );

   mexp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_type  (req_tuser),
      .req_data  (req_tdata),
      .status    (status),
      .acc_value (acc_value)
   );

   assign out_load = (ctrl.op == OP_OUT_ACC) || (ctrl.op == OP_OUT_BAD) ||
                     (ctrl.op == OP_OUT_ONE);

   always_comb begin
      rsp_result_in = rsp_result_ff;
      rsp_bad_in    = rsp_bad_ff;
      unique case (ctrl.op)
         OP_OUT_ACC: begin
            rsp_result_in = acc_value;
            rsp_bad_in    = 1'b0;
         end
         OP_OUT_BAD: begin
            rsp_result_in = '0;
            rsp_bad_in    = 1'b1;
         end
         OP_OUT_ONE: begin
            rsp_result_in = MOD_WIDTH'(1);
            rsp_bad_in    = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      priority if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'(rsp_result_ff);
   assign rsp_tuser  = rsp_bad_ff;

   `MEXP_ASSERT(a_no_overwrite, out_load |-> !rsp_valid_ff, "result register overwritten")
   `MEXP_ASSERT(a_bad_is_zero, (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0), "rejected request with nonzero result")
   `MEXP_ASSERT(a_one_at_a_time, (req_tvalid && req_tready) |=> !req_tready, "second transaction taken while busy")
   `MEXP_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid, "result valid straight after reset")

endmodule

FILE: hdl/mexp_seq.sv
// ----------------------------------------------------------------------------
// mexp_seq
// step counter, program table and jump logic driving the datapath
// ----------------------------------------------------------------------------
module mexp_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  out_full,
   input  mexp_pkg::status_type  status,
   output mexp_pkg::ctrl_type    ctrl,
   output logic                  req_tready
);
   import mexp_pkg::*;

   logic [PC_WIDTH-1:0] pc_ff;
   logic [PC_WIDTH-1:0] pc_in;
   ucode_type           cw;
   logic                stall;
   logic                jump;

   assign cw    = ucode_rom(pc_ff);
   // a finishing step waits for the result register to drain
   assign stall = cw.wait_out && out_full;

   always_comb begin
      unique case (cw.cond)
         C_NEXT:      jump = 1'b0;
         C_ALWAYS:    jump = 1'b1;
         C_NO_REQ:    jump = !req_tvalid;
         C_BAD:       jump = status.bad;
         C_EXP_ZERO:  jump = status.exp_zero;
         C_MUL_MORE:  jump = status.mul_more;
         C_EBIT_ZERO: jump = !status.ebit;
         C_ECNT_MORE: jump = status.ecnt_more;
         default:     jump = 1'b0;
      endcase
   end

   always_comb begin
      priority if (stall) begin
         pc_in = pc_ff;
      end else if (jump) begin
         pc_in = cw.target;
      end else begin
         pc_in = pc_ff + PC_WIDTH'(1);
      end
   end

   always_comb begin
      ctrl.op    = stall ? OP_NOP : cw.op;
      // nothing is taken in while reset is held
      req_tready = (cw.op == OP_ACCEPT) && !reset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

FILE: hdl/mexp_datapath.sv
// ----------------------------------------------------------------------------
// mexp_datapath
// operand registers, exponent shifter and bit-serial modular multiplier
// ----------------------------------------------------------------------------
`include "modular_exponentiation_macros.svh"

module mexp_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mexp_pkg::ctrl_type                    ctrl,
   input  logic                                  req_type,
   input  logic [mexp_pkg::REQ_DATA_WIDTH-1:0]   req_data,
   output mexp_pkg::status_type                  status,
   output logic [mexp_pkg::MOD_WIDTH-1:0]        acc_value
);
   import mexp_pkg::*;

   localparam int TW = MOD_WIDTH + 2;

   logic                  inv_ff;
   logic [MOD_WIDTH-1:0]  mod_ff,  mod_in;
   logic [MOD_WIDTH-1:0]  base_ff, base_in;
   logic [EREG_WIDTH-1:0] exp_ff,  exp_in;
   logic [ECNT_WIDTH-1:0] ecnt_ff, ecnt_in;
   logic [MOD_WIDTH-1:0]  acc_ff,  acc_in;
   logic [MOD_WIDTH-1:0]  ma_ff,   ma_in;
   logic [MOD_WIDTH-1:0]  mb_ff,   mb_in;
   logic [MOD_WIDTH-1:0]  macc_ff, macc_in;
   logic [MCNT_WIDTH-1:0] mcnt_ff, mcnt_in;
   logic                  inv_in;

   logic [MOD_WIDTH-1:0]  one_mod;
   logic [TW-1:0]         sum;
   logic [TW-1:0]         less_m;
   logic [TW-1:0]         less_2m;
   logic [MOD_WIDTH-1:0]  mul_next;

   // 1 reduced by the modulus
   assign one_mod = (mod_ff == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);

   // one multiplier bit: 2*acc + bit*a stays below 3m, so two trial subtracts
   always_comb begin
      sum     = {1'b0, macc_ff, 1'b0} + (mb_ff[MOD_WIDTH-1] ? {2'b00, ma_ff} : '0);
      less_m  = sum - {2'b00, mod_ff};
      less_2m = sum - {1'b0, mod_ff, 1'b0};
      priority if (!less_2m[TW-1]) begin
         mul_next = less_2m[MOD_WIDTH-1:0];
      end else if (!less_m[TW-1]) begin
         mul_next = less_m[MOD_WIDTH-1:0];
      end else begin
         mul_next = sum[MOD_WIDTH-1:0];
      end
   end

   always_comb begin
      inv_in  = inv_ff;
      mod_in  = mod_ff;
      base_in = base_ff;
      exp_in  = exp_ff;
      ecnt_in = ecnt_ff;
      acc_in  = acc_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      macc_in = macc_ff;
      mcnt_in = mcnt_ff;
      unique case (ctrl.op)
         OP_ACCEPT: begin
            inv_in  = req_type;
            base_in = req_data[MOD_WIDTH-1:0];
            exp_in  = EREG_WIDTH'(req_data[MOD_WIDTH +: EXP_WIDTH]);
            mod_in  = req_data[MOD_WIDTH + EXP_WIDTH +: MOD_WIDTH];
         end
         OP_LOAD_EXP: begin
            if (inv_ff) begin
               exp_in = EREG_WIDTH'(mod_ff - MOD_WIDTH'(2));
            end
            ecnt_in = ECNT_WIDTH'(EREG_WIDTH - 1);
         end
         OP_SETUP_RBASE: begin
            ma_in   = one_mod;
            mb_in   = base_ff;
            macc_in = '0;
            mcnt_in = MCNT_WIDTH'(MOD_WIDTH - 1);
         end
         OP_MUL_STEP: begin
            macc_in = mul_next;
            mb_in   = {mb_ff[MOD_WIDTH-2:0], 1'b0};
            mcnt_in = mcnt_ff - MCNT_WIDTH'(1);
         end
         OP_SAVE_BASE: begin
            base_in = macc_ff;
            acc_in  = one_mod;
         end
         OP_SETUP_SQ: begin
            ma_in   = acc_ff;
            mb_in   = acc_ff;
            macc_in = '0;
            mcnt_in = MCNT_WIDTH'(MOD_WIDTH - 1);
         end
         OP_SAVE_ACC: begin
            acc_in = macc_ff;
         end
         OP_SETUP_MB: begin
            ma_in   = acc_ff;
            mb_in   = base_ff;
            macc_in = '0;
            mcnt_in = MCNT_WIDTH'(MOD_WIDTH - 1);
         end
         OP_NEXT_BIT: begin
            exp_in  = {exp_ff[EREG_WIDTH-2:0], 1'b0};
            ecnt_in = ecnt_ff - ECNT_WIDTH'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      inv_ff  <= inv_in;
      mod_ff  <= mod_in;
      base_ff <= base_in;
      exp_ff  <= exp_in;
      ecnt_ff <= ecnt_in;
      acc_ff  <= acc_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      macc_ff <= macc_in;
      mcnt_ff <= mcnt_in;
   end

   always_comb begin
      status.bad       = (mod_ff == '0) || (inv_ff && (mod_ff == MOD_WIDTH'(1)));
      status.exp_zero  = (exp_ff == '0);
      status.mul_more  = (mcnt_ff != '0);
      status.ebit      = exp_ff[EREG_WIDTH-1];
      status.ecnt_more = (ecnt_ff != '0);
   end

   assign acc_value = acc_ff;

   `MEXP_ASSERT(a_macc_reduced, (ctrl.op == OP_MUL_STEP) |-> (macc_ff < mod_ff), "multiplier accumulator not reduced")
   `MEXP_ASSERT(a_mult_operand_reduced, (ctrl.op == OP_MUL_STEP) |-> (ma_ff < mod_ff), "multiplicand not reduced")

endmodule

FILE: sim/modular_exponentiation_checker.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_checker
// watches both channels, predicts each power and compares it with the response
// ----------------------------------------------------------------------------
module modular_exponentiation_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   // base_value, exponent_value, modulus_value, zero fill
   input  logic [mexp_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // req_type
   input  logic                                req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // power_result
   input  logic [mexp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // bad_modulus
   input  logic                                rsp_tuser,
   output int                                  error_count,
   output int                                  pending_count
);
   import mexp_pkg::*;

   localparam int MW = MOD_WIDTH;
   localparam int EW = EXP_WIDTH;

   typedef struct packed {
      logic [MW-1:0] power;
      logic          bad;
   } power_expect_type;

   power_expect_type expected_powers[$];
   int               n_mismatch = 0;
   int               n_pending  = 0;

   assign error_count   = n_mismatch;
   assign pending_count = n_pending;

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      n_mismatch++;
   endtask

   // square-and-multiply over the full 64-bit exponent, products kept exact
   function automatic power_expect_type predict_power(input logic          inverse,
                                                      input logic [MW-1:0] base,
                                                      input logic [EW-1:0] expo,
                                                      input logic [MW-1:0] modulus);
      power_expect_type r;
      logic [63:0]      e;
      logic [2*MW-1:0]  m;
      logic [2*MW-1:0]  b;
      logic [2*MW-1:0]  acc;
      int               i;
      r.power = '0;
      r.bad   = 1'b0;
      if (modulus == '0 || (inverse && modulus < 2)) begin
         r.bad = 1'b1;
         return r;
      end
      e = inverse ? (64'(modulus) - 64'd2) : 64'(expo);
      // a zero exponent gives one unreduced, even for modulus one
      if (e == 64'd0) begin
         r.power = MW'(1);
         return r;
      end
      m   = (2*MW)'(modulus);
      b   = (2*MW)'(base) % m;
      acc = (2*MW)'(1) % m;
      for (i = 63; i >= 0; i--) begin
         acc = (acc * acc) % m;
         if (e[i])
            acc = (acc * b) % m;
      end
      r.power = acc[MW-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      power_expect_type want;
      if (!reset) begin
         // retire the response first so it always meets the oldest request
         if (rsp_tvalid && rsp_tready) begin
            if (expected_powers.size() == 0) begin
               report_mismatch($sformatf("response %h/%b with nothing outstanding",
                                         rsp_tdata, rsp_tuser));
            end else begin
               want = expected_powers.pop_front();
               if (rsp_tdata[MW-1:0] !== want.power)
                  report_mismatch($sformatf("power_result %h, expected %h",
                                            rsp_tdata[MW-1:0], want.power));
               if (rsp_tuser !== want.bad)
                  report_mismatch($sformatf("bad_modulus %b, expected %b",
                                            rsp_tuser, want.bad));
            end
         end
         if (req_tvalid && req_tready)
            expected_powers.push_back(predict_power(req_tuser,
                                                    req_tdata[MW-1:0],
                                                    req_tdata[MW+EW-1:MW],
                                                    req_tdata[2*MW+EW-1:MW+EW]));
         n_pending = expected_powers.size();
      end
   end

endmodule

FILE: sim/modular_exponentiation_tb.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// stimulus and verdict for the modular exponentiator
// ----------------------------------------------------------------------------
// Directed requests cover the edge values, both modes, rejected moduli and
// zero exponents; random requests follow, with idle bursts on both channels
// until a calm tail. The checker predicts and compares every response.
module modular_exponentiation_tb;
   import mexp_pkg::*;

   localparam int MW = MOD_WIDTH;
   localparam int EW = EXP_WIDTH;
   localparam int RANDOM_REQUESTS = 110;
   localparam int CALM_FROM       = 95;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;
   logic                      req_tuser  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tuser;
   int                        mismatch_count;
   int                        outstanding;
   bit                        calm = 1'b0;

   logic [MW-1:0] primes [6] = '{32'd4294967291, 32'd2147483647, 32'd1000000007,
                                 32'd998244353, 32'd65521, 32'd251};

   modular_exponentiation DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   modular_exponentiation_checker results_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (mismatch_count),
      .pending_count (outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // about 130 requests at their longest, taken several times over
   initial begin
      #6_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic send_request(input logic          inverse,
                               input logic [MW-1:0] b,
                               input logic [EW-1:0] e,
                               input logic [MW-1:0] m);
      if (!calm && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= inverse;
      req_tdata  <= {{(REQ_DATA_WIDTH-2*MW-EW){1'b0}}, m, e, b};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [MW-1:0] pick_modulus();
      logic [MW-1:0] m;
      case ($urandom_range(0, 9))
         0:       m = MW'($urandom_range(0, 2));
         1, 2:    m = MW'($urandom_range(3, 255));
         3, 4, 5: m = MW'($urandom);
         6:       m = '1 - MW'($urandom_range(0, 15));
         default: m = primes[$urandom_range(0, 5)];
      endcase
      return m;
   endfunction

   // response side back-pressure
   initial begin
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   initial begin
      logic          inverse;
      logic [MW-1:0] b;
      logic [EW-1:0] e;
      logic [MW-1:0] m;
      int            n;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(1'b0, 32'd2, 63'd10, 32'd1000);
      send_request(1'b0, '0, '0, '0);
      send_request(1'b0, '1, '1, '0);
      send_request(1'b1, 32'd5, 63'd7, '0);
      send_request(1'b1, 32'd5, 63'd7, 32'd1);
      // inverse with modulus two means a zero exponent
      send_request(1'b1, 32'd1, 63'd3, 32'd2);
      send_request(1'b1, 32'd0, '1, 32'd2);
      send_request(1'b0, 32'd9, 63'd0, 32'd1);
      send_request(1'b0, 32'd9, 63'd5, 32'd1);
      send_request(1'b0, '1, '1, '1);
      send_request(1'b0, '1, 63'd1, 32'd7);
      send_request(1'b0, '0, 63'd3, 32'd13);
      send_request(1'b0, '0, 63'd0, 32'd13);
      send_request(1'b1, 32'd3, 63'd0, 32'd4294967291);
      send_request(1'b1, '0, 63'd0, 32'd65521);
      send_request(1'b1, 32'd2000006, 63'd0, 32'd1000003);
      send_request(1'b1, '1, 63'd0, 32'd3);
      // non-prime modulus in inverse mode is not checked
      send_request(1'b1, 32'd12345, 63'd0, '1);
      send_request(1'b1, 32'd2, '1, 32'd1000000007);
      send_request(1'b0, 32'd3, 63'h4000_0000_0000_0000, 32'd1000000007);
      send_request(1'b0, 32'haaaa_aaaa, 63'h5555_5555_5555_5555, 32'h8000_0001);
      send_request(1'b0, 32'h5555_5555, 63'h2aaa_aaaa_aaaa_aaaa, 32'hffff_fffe);

      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == CALM_FROM)
            calm = 1'b1;
         inverse = ($urandom_range(0, 3) == 0);
         m = pick_modulus();
         case ($urandom_range(0, 7))
            0:       b = '0;
            1:       b = '1;
            2:       b = m * MW'($urandom_range(1, 3));
            default: b = MW'($urandom);
         endcase
         case ($urandom_range(0, 7))
            0:       e = '0;
            1:       e = '1;
            2:       e = EW'($urandom_range(1, 40));
            default: e = EW'({$urandom, $urandom});
         endcase
         send_request(inverse, b, e, m);
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
